/* rtl/spcc_pkg.sv */
package spcc_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int SQ_W = 66;
  localparam int ROOT_W = SQ_W / 2;
  localparam logic [33:0] SELF_K = 34'd15141882927;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic kind;
    logic same;
    logic neg;
    logic [31:0] mag;
    logic [63:0] self_val;
  } pre_tag_t;

  typedef struct packed {
    logic kind;
    logic same;
    logic neg;
    logic [63:0] self_val;
  } div_tag_t;

endpackage

/* rtl/square_patch_coupling_coefficient_unit.sv */
// Square patch coupling coefficient unit.
// Configuration: side_length_we writes side_length (unsigned fixed point with
// COORD_FRAC_BITS fraction bits). Write it only while no item is in flight.
// Input: an item is taken at a rising edge with start high and busy low. busy
// is always low, so one item may enter every cycle.
// Output: each item yields one result, shown on value and saturated for one
// cycle with done high. The receiver cannot stall; results must be taken.
// Pipeline: three front stages (differences, squares, sum), a 33 stage square
// root pipeline at one root bit per stage, a numerator stage, a restoring
// divider pipeline of 96 - COORD_FRAC_BITS stages at one quotient bit per
// stage, and the output register.
// Throughput: one item per cycle.
// Reset: rst clears side_length and all valid bits; items in flight are lost.
module square_patch_coupling_coefficient_unit import spcc_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               side_length_we,
  input  logic [31:0]        side_length,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic signed [31:0] own_x,
  input  logic signed [31:0] own_y,
  input  logic signed [31:0] own_z,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic signed [31:0] other_z,
  input  logic signed [31:0] charge,
  output logic               done,
  output logic signed [63:0] value,
  output logic               saturated
);

  localparam int NUM_W = 96 - COORD_FRAC_BITS;
  localparam int PRE_W = $bits(pre_tag_t);
  localparam int DTAG_W = $bits(div_tag_t);

  logic [31:0] side;

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else if (side_length_we) begin
      side <= side_length;
    end
  end

  assign busy = 1'b0;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  // Stage 1: coordinate differences and charge magnitude.
  logic        v1;
  logic [31:0] dx1, dy1, dz1;
  logic        kind1, neg1;
  logic [31:0] mag1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    dx1   <= abs_diff(own_x, other_x);
    dy1   <= abs_diff(own_y, other_y);
    dz1   <= abs_diff(own_z, other_z);
    kind1 <= kind;
    neg1  <= charge[31];
    mag1  <= charge[31] ? (~charge + 32'd1) : charge;
  end

  // Stage 2: squares and the self term product.
  logic        v2;
  logic [63:0] qx2, qy2, qz2;
  logic [65:0] selfp2;
  logic        kind2, neg2, same2;
  logic [31:0] mag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    qx2    <= 64'(dx1) * 64'(dx1);
    qy2    <= 64'(dy1) * 64'(dy1);
    qz2    <= 64'(dz1) * 64'(dz1);
    selfp2 <= 66'(side) * 66'(SELF_K);
    same2  <= (dx1 == '0) && (dy1 == '0) && (dz1 == '0);
    kind2  <= kind1;
    neg2   <= neg1;
    mag2   <= mag1;
  end

  // Stage 3: sum of squares.
  logic        v3;
  logic [SQ_W-1:0] s3;
  pre_tag_t    t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3          <= SQ_W'(qx2) + SQ_W'(qy2) + SQ_W'(qz2);
    t3.kind     <= kind2;
    t3.same     <= same2;
    t3.neg      <= neg2;
    t3.mag      <= mag2;
    t3.self_val <= 64'(selfp2 >> COORD_FRAC_BITS);
  end

  logic              vr;
  logic [ROOT_W-1:0] root_r;
  logic [PRE_W-1:0]  tr_bits;
  pre_tag_t          tr;

  spcc_sqrt_pipe #(.TAG_W(PRE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v3),
    .s_in      (s3),
    .tag_in    (PRE_W'(t3)),
    .valid_out (vr),
    .root_out  (root_r),
    .tag_out   (tr_bits)
  );

  assign tr = pre_tag_t'(tr_bits);

  // Numerator: coupling side^2 as Q32.48 at 16 frac bits, else |charge| * 2^32.
  logic              vn;
  logic [NUM_W-1:0]  num_n;
  logic [ROOT_W-1:0] den_n;
  div_tag_t          tn;

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else begin
      vn <= vr;
    end
    if (tr.kind) begin
      num_n <= NUM_W'({tr.mag, 32'd0});
    end else begin
      num_n <= NUM_W'(64'(side) * 64'(side)) << (32 - COORD_FRAC_BITS);
    end
    den_n       <= (root_r == '0) ? ROOT_W'(1) : root_r;
    tn.kind     <= tr.kind;
    tn.same     <= tr.same;
    tn.neg      <= tr.neg;
    tn.self_val <= tr.self_val;
  end

  logic              vq;
  logic [NUM_W-1:0]  quot;
  logic [DTAG_W-1:0] tq_bits;
  div_tag_t          tq;

  spcc_div_pipe #(.NUM_W(NUM_W), .DEN_W(ROOT_W), .TAG_W(DTAG_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (vn),
    .num_in    (num_n),
    .den_in    (den_n),
    .tag_in    (DTAG_W'(tn)),
    .valid_out (vq),
    .quot_out  (quot),
    .tag_out   (tq_bits)
  );

  assign tq = div_tag_t'(tq_bits);

  logic [63:0] value_next;
  logic        sat_next;

  always_comb begin
    value_next = quot[63:0];
    sat_next   = 1'b0;
    if (tq.same) begin
      value_next = tq.kind ? 64'd0 : tq.self_val;
    end else if (tq.kind) begin
      value_next = tq.neg ? (~quot[63:0] + 64'd1) : quot[63:0];
    end else if (quot[NUM_W-1:63] != '0) begin
      value_next = POS_MAX;
      sat_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vq;
    end
    value     <= value_next;
    saturated <= sat_next;
  end

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> value == POS_MAX)
    else $error("saturated result is not the positive limit");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vq))
    else $error("result strobe without an item leaving the divider");

  a_sat_kind: assert property (@(posedge clk) disable iff (rst)
    vq && (tq.kind || tq.same) |=> !saturated)
    else $error("potential or self term flagged as saturated");

endmodule

/* rtl/spcc_sqrt_pipe.sv */
module spcc_sqrt_pipe import spcc_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  logic [SQ_W-1:0]   s_in,
  input  logic [TAG_W-1:0]  tag_in,
  output logic              valid_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [TAG_W-1:0]  tag_out
);

  localparam int STAGES = ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [STAGES-1:0] vld;
  logic [SQ_W-1:0]   sreg      [STAGES];
  logic [ROOT_W-1:0] root      [STAGES];
  logic [REM_W-1:0]  rem       [STAGES];
  logic [TAG_W-1:0]  tag       [STAGES];
  logic [SQ_W-1:0]   sreg_next [STAGES];
  logic [ROOT_W-1:0] root_next [STAGES];
  logic [REM_W-1:0]  rem_next  [STAGES];

  // One root bit per stage: bring down two radicand bits, try 4*root+1.
  always_comb begin
    logic [SQ_W-1:0]   s_src;
    logic [ROOT_W-1:0] r_src;
    logic [REM_W-1:0]  m_src;
    logic [REM_W-1:0]  cand;
    logic [REM_W-1:0]  trial;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        s_src = s_in;
        r_src = '0;
        m_src = '0;
      end else begin
        s_src = sreg[i-1];
        r_src = root[i-1];
        m_src = rem[i-1];
      end
      cand  = {m_src[REM_W-3:0], s_src[SQ_W-1 -: 2]};
      trial = {1'b0, r_src, 2'b01};
      sreg_next[i] = s_src << 2;
      if (cand >= trial) begin
        rem_next[i]  = cand - trial;
        root_next[i] = {r_src[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[i]  = cand;
        root_next[i] = {r_src[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], valid_in};
    end
    for (int i = 0; i < STAGES; i++) begin
      sreg[i] <= sreg_next[i];
      root[i] <= root_next[i];
      rem[i]  <= rem_next[i];
      tag[i]  <= (i == 0) ? tag_in : tag[(i == 0) ? 0 : i-1];
    end
  end

  assign valid_out = vld[STAGES-1];
  assign root_out  = root[STAGES-1];
  assign tag_out   = tag[STAGES-1];

endmodule

/* rtl/spcc_div_pipe.sv */
module spcc_div_pipe #(
  parameter int NUM_W = 80,
  parameter int DEN_W = 33,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid_in,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  input  logic [TAG_W-1:0] tag_in,
  output logic             valid_out,
  output logic [NUM_W-1:0] quot_out,
  output logic [TAG_W-1:0] tag_out
);

  logic [NUM_W-1:0] vld;
  // The numerator shifts out at the top while quotient bits shift in below.
  logic [NUM_W-1:0] nq      [NUM_W];
  logic [DEN_W-1:0] rem     [NUM_W];
  logic [DEN_W-1:0] den     [NUM_W];
  logic [TAG_W-1:0] tag     [NUM_W];
  logic [NUM_W-1:0] nq_next [NUM_W];
  logic [DEN_W-1:0] rem_next[NUM_W];

  always_comb begin
    logic [NUM_W-1:0] n_src;
    logic [DEN_W-1:0] m_src;
    logic [DEN_W-1:0] d_src;
    logic [DEN_W:0]   cand;
    for (int i = 0; i < NUM_W; i++) begin
      if (i == 0) begin
        n_src = num_in;
        m_src = '0;
        d_src = den_in;
      end else begin
        n_src = nq[i-1];
        m_src = rem[i-1];
        d_src = den[i-1];
      end
      cand = {m_src, n_src[NUM_W-1]};
      if (cand >= {1'b0, d_src}) begin
        rem_next[i] = DEN_W'(cand - {1'b0, d_src});
        nq_next[i]  = {n_src[NUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = cand[DEN_W-1:0];
        nq_next[i]  = {n_src[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NUM_W-2:0], valid_in};
    end
    for (int i = 0; i < NUM_W; i++) begin
      nq[i]  <= nq_next[i];
      rem[i] <= rem_next[i];
      den[i] <= (i == 0) ? den_in : den[(i == 0) ? 0 : i-1];
      tag[i] <= (i == 0) ? tag_in : tag[(i == 0) ? 0 : i-1];
    end
  end

  assign valid_out = vld[NUM_W-1];
  assign quot_out  = nq[NUM_W-1];
  assign tag_out   = tag[NUM_W-1];

endmodule

/* tb/patch_coupling_checker.sv */
`timescale 1ns / 100ps
module patch_coupling_checker import spcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               side_length_we,
  input  logic [31:0]        side_length,
  input  logic               start,
  input  logic               busy,
  input  logic               kind,
  input  logic signed [31:0] own_x,
  input  logic signed [31:0] own_y,
  input  logic signed [31:0] own_z,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic signed [31:0] other_z,
  input  logic signed [31:0] charge,
  input  logic               done,
  input  logic signed [63:0] value,
  input  logic               saturated,
  output int                 errors,
  output int                 pending
);

  localparam logic KIND_COUPLING = 1'b0;
  localparam int FRAC = COORD_FRAC_BITS_DEF;

  typedef struct packed {
    logic [63:0] value;
    logic        saturated;
  } element_t;

  element_t   element_q[$];
  logic [31:0] side_now;

  function automatic logic [32:0] coord_gap(logic signed [31:0] a, logic signed [31:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    if (diff < 0) diff = -diff;
    return diff[32:0];
  endfunction

  // Computes the matrix element for one pair of patches.
  function automatic element_t matrix_element(logic k, logic signed [31:0] ax,
      logic signed [31:0] ay, logic signed [31:0] az, logic signed [31:0] bx,
      logic signed [31:0] by, logic signed [31:0] bz, logic signed [31:0] q,
      logic [31:0] side);
    logic [32:0]  gx, gy, gz;
    logic [69:0]  sum_sq, cand, cand_sq;
    logic [63:0]  root_d;
    logic [127:0] num, quot;
    logic [31:0]  mag;
    logic [63:0]  pot;
    element_t     res;
    gx = coord_gap(ax, bx);
    gy = coord_gap(ay, by);
    gz = coord_gap(az, bz);
    res = '0;
    if (gx == 0 && gy == 0 && gz == 0) begin
      if (k == KIND_COUPLING) begin
        quot = ({96'b0, side} * {94'b0, SELF_K}) >> FRAC;
        res.saturated = quot > {64'b0, POS_MAX};
        res.value = res.saturated ? POS_MAX : quot[63:0];
      end
      return res;
    end
    sum_sq = {37'b0, gx} * {37'b0, gx} + {37'b0, gy} * {37'b0, gy}
           + {37'b0, gz} * {37'b0, gz};
    root_d = 0;
    for (int b = 34; b >= 0; b--) begin
      cand = {6'b0, root_d} | (70'd1 << b);
      cand_sq = cand * cand;
      if (cand_sq <= sum_sq) root_d = cand[63:0];
    end
    if (root_d == 0) root_d = 1;
    if (k == KIND_COUPLING) begin
      num = ({96'b0, side} * {96'b0, side}) << (32 - FRAC);
      quot = num / {64'b0, root_d};
      res.saturated = quot > {64'b0, POS_MAX};
      res.value = res.saturated ? POS_MAX : quot[63:0];
    end else begin
      mag = q[31] ? -q : q;
      pot = {mag, 32'b0} / root_d;
      res.value = q[31] ? -pot : pot;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  assign pending = element_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    element_t got, want;
    if (rst) begin
      side_now <= '0;
      element_q.delete();
    end else begin
      if (done) begin
        got.value = value;
        got.saturated = saturated;
        if (element_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no item waiting", value));
        end else begin
          want = element_q.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("value %h, expected %h", got.value, want.value));
          if (got.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b", got.saturated,
                                      want.saturated));
        end
      end
      if (start && !busy)
        element_q.push_back(matrix_element(kind, own_x, own_y, own_z, other_x, other_y,
                                           other_z, charge, side_now));
      if (side_length_we) side_now <= side_length;
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
module testbench;

  localparam logic KIND_COUPLING = 1'b0;
  localparam logic KIND_POTENTIAL = 1'b1;
  localparam int LATENCY = 140;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

  logic               clk, rst;
  logic               side_length_we;
  logic [31:0]        side_length;
  logic               start, busy, kind, done, saturated;
  logic signed [31:0] own_x, own_y, own_z, other_x, other_y, other_z, charge;
  logic signed [63:0] value;
  int                 errors, pending, cycles;

  square_patch_coupling_coefficient_unit dut (.*);

  patch_coupling_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_side(logic [31:0] v);
    side_length_we <= 1;
    side_length <= v;
    @(negedge clk);
    side_length_we <= 0;
    @(negedge clk);
  endtask

  // Drives one item at a falling edge and holds it until the block takes it.
  task automatic send_pair(logic k, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                           logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                           logic [31:0] q, int gap);
    start <= 1;
    kind <= k;
    own_x <= ax; own_y <= ay; own_z <= az;
    other_x <= bx; other_y <= by; other_z <= bz;
    charge <= q;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return $urandom;
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  task automatic drain();
    start <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_phase(int count, bit busy_sender);
    logic [31:0] ax, ay, az, bx, by, bz, q;
    int gap;
    for (int i = 0; i < count; i++) begin
      ax = pick_coord(); ay = pick_coord(); az = pick_coord();
      if ($urandom_range(0, 9) == 0) begin
        bx = ax; by = ay; bz = az;
      end else if ($urandom_range(0, 1) == 0) begin
        bx = ax + $urandom_range(0, 600) - 300;
        by = ay + $urandom_range(0, 600) - 300;
        bz = az + $urandom_range(0, 600) - 300;
      end else begin
        bx = pick_coord(); by = pick_coord(); bz = pick_coord();
      end
      case ($urandom_range(0, 7))
        0: q = MOST_NEG;
        1: q = MOST_POS;
        default: q = $urandom;
      endcase
      gap = (busy_sender && $urandom_range(0, 2) != 0) ? $urandom_range(0, 16) : 0;
      send_pair(1'($urandom_range(0, 1)), ax, ay, az, bx, by, bz, q, gap);
    end
    drain();
  endtask

  initial begin
    logic [31:0] sides[5];
    cycles = 0;
    rst = 1;
    side_length_we = 0; side_length = 0;
    start = 0; kind = 0; charge = 0;
    own_x = 0; own_y = 0; own_z = 0; other_x = 0; other_y = 0; other_z = 0;
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Reset value of the side, then the largest side: self terms and saturation.
    send_pair(KIND_COUPLING, 5, 6, 7, 5, 6, 7, 0, 0);
    send_pair(KIND_COUPLING, 0, 0, 0, 1, 0, 0, 0, 0);
    drain();
    write_side(MOST_POS << 1 | 1);
    send_pair(KIND_COUPLING, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(KIND_COUPLING, 0, 0, 0, 0, 0, 1, 0, 1);
    send_pair(KIND_COUPLING, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS,
              0, 0);
    send_pair(KIND_POTENTIAL, 3, 3, 3, 3, 3, 3, MOST_POS, 0);
    send_pair(KIND_POTENTIAL, 0, 0, 0, 1, 0, 0, MOST_NEG, 2);
    send_pair(KIND_POTENTIAL, 0, 0, 0, 0, 1, 0, MOST_POS, 0);
    send_pair(KIND_POTENTIAL, MOST_POS, 0, 0, MOST_NEG, 0, 0, MOST_NEG, 0);
    send_pair(KIND_POTENTIAL, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS,
              32'hFFFF_FFFF, 0);
    send_pair(KIND_POTENTIAL, 0, 0, 0, 7, 7, 7, 0, 3);
    drain();
    write_side(32'h0001_0000);
    send_pair(KIND_COUPLING, 1, 2, 3, 1, 2, 3, 0, 0);
    send_pair(KIND_COUPLING, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0);
    send_pair(KIND_COUPLING, MOST_NEG, 0, 0, MOST_POS, 0, 0, 0, 0);
    drain();

    sides[0] = 0;
    sides[1] = 32'hFFFF_FFFF;
    sides[2] = 1;
    sides[3] = $urandom;
    sides[4] = $urandom_range(0, 32'h0010_0000);
    for (int p = 0; p < 5; p++) begin
      write_side(sides[p]);
      random_phase(340, p != 2);
    end

    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
